FILE: hdl/modbus_read_response_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Modbus read response parser assertion macros
// Clocked, reset-qualified property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_RESPONSE_PARSER_TOP_ASSERT_SVH
`define MODBUS_READ_RESPONSE_PARSER_TOP_ASSERT_SVH

// check prop on every clock edge outside reset
`define MBRP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that cond never holds outside reset
`define MBRP_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: hdl/mbrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus read response parser package
// Shared frame constants, queue entry type and CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrp_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int VALUE_W = 13;
   localparam int POS_W   = 4;
   localparam int RSP_TDATA_W = 32;
   localparam int PAD_W   = RSP_TDATA_W - 2 * VALUE_W;

   // frame positions
   localparam logic [POS_W-1:0] POS_ADDR     = 4'd0;
   localparam logic [POS_W-1:0] POS_FUNC     = 4'd1;
   localparam logic [POS_W-1:0] POS_COUNT    = 4'd2;
   localparam logic [POS_W-1:0] POS_DATA0    = 4'd3;
   localparam logic [POS_W-1:0] POS_DATA1    = 4'd4;
   localparam logic [POS_W-1:0] POS_DATA2    = 4'd5;
   localparam logic [POS_W-1:0] POS_DATA3    = 4'd6;
   localparam logic [POS_W-1:0] POS_CRC_LOW  = 4'd7;
   localparam logic [POS_W-1:0] POS_CRC_HIGH = 4'd8;

   localparam logic [BYTE_W-1:0] FUNC_READ  = 8'd3;
   localparam logic [BYTE_W-1:0] DATA_COUNT = 8'd4;

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   // floor(w / 10) == (w * 52429) >> 19 for every 16-bit w
   localparam logic [16:0] DIV10_MULT  = 17'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef struct packed {
      logic              crc_ok;
      logic [WORD_W-1:0] first_word;
      logic [WORD_W-1:0] second_word;
   } frame_type;

   function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: hdl/modbus_read_response_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus read response parser
// Hunts received bytes for a two-register read reply, checks its CRC-16 and
// returns both registers divided by ten, or zeros if the CRC fails.
//
//   channel  dir  payload
//   req_     in   tdata[7:0]   rx_byte
//   rsp_     out  tuser        crc_ok; tdata[12:0] first_value,
//                              tdata[25:13] second_value
//   csr_     in   data[7:0]    expected_address
//
// One byte is taken per cycle while the frame queue has room. After the
// ninth byte's transfer the frame is written into the frame queue and then
// loads the output register once that register is empty or being taken.
// req_tready drops only while the frame queue is full. Reset zeroes the
// frame position, seeds the CRC with FFFF and sets the address register to 1.
// ----------------------------------------------------------------------------
`include "modbus_read_response_parser_top_assert.svh"

module modbus_read_response_parser_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [12:0] first_value, [25:13] second_value
   output logic        rsp_tuser,   // [0] crc_ok
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] expected_address
);

   logic [mbrp_pkg::BYTE_W-1:0] expected_address_ff;
   logic                        q_push, q_ready, q_pop, q_valid;
   mbrp_pkg::frame_type         push_entry, pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_address_ff <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         expected_address_ff <= csr_data;
      end
   end

   mbrp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .expected_address (expected_address_ff),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   mbrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   mbrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `MBRP_ASSERT(a_push_has_room, q_push |-> q_ready, "frame pushed into full queue")
   `MBRP_ASSERT(a_push_lands, q_push |=> q_valid, "pushed frame missing from queue")
   `MBRP_ASSERT_NEVER(a_bad_crc_zero, rsp_tvalid && !rsp_tuser && (rsp_tdata != '0), "failed frame carries values")

endmodule

FILE: hdl/mbrp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus read response parser front end
// Tracks frame position, header match and running CRC; emits one frame entry.
// ----------------------------------------------------------------------------
module mbrp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mbrp_pkg::BYTE_W-1:0]     req_tdata,
   input  logic [mbrp_pkg::BYTE_W-1:0]     expected_address,
   input  logic                            q_ready,
   output logic                            q_push,
   output mbrp_pkg::frame_type             q_entry
);

   logic [mbrp_pkg::POS_W-1:0]  byte_count_ff, byte_count_in;
   logic [mbrp_pkg::WORD_W-1:0] crc_ff, crc_in;
   logic [mbrp_pkg::BYTE_W-1:0] payload_ff [4];
   logic [mbrp_pkg::BYTE_W-1:0] crc_low_ff;
   logic [mbrp_pkg::WORD_W-1:0] crc_next;
   logic [mbrp_pkg::WORD_W-1:0] crc_got;
   logic [1:0]                  data_idx;
   logic                        accept;
   logic                        crc_match;

   assign req_tready = q_ready;
   assign accept     = req_tvalid & req_tready;
   assign crc_next   = mbrp_pkg::crc_feed(crc_ff, req_tdata);
   assign data_idx   = byte_count_ff[1:0] + 2'd1;
   assign crc_got    = {req_tdata, crc_low_ff};
   assign crc_match  = (crc_got == crc_ff);

   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      q_push        = 1'b0;
      unique case (byte_count_ff)
         mbrp_pkg::POS_ADDR: begin
            if (req_tdata == expected_address) begin
               byte_count_in = mbrp_pkg::POS_FUNC;
               crc_in        = crc_next;
            end
         end
         mbrp_pkg::POS_FUNC: begin
            if (req_tdata == mbrp_pkg::FUNC_READ) begin
               byte_count_in = mbrp_pkg::POS_COUNT;
               crc_in        = crc_next;
            end
         end
         mbrp_pkg::POS_COUNT: begin
            if (req_tdata == mbrp_pkg::DATA_COUNT) begin
               byte_count_in = mbrp_pkg::POS_DATA0;
               crc_in        = crc_next;
            end
         end
         mbrp_pkg::POS_DATA0, mbrp_pkg::POS_DATA1,
         mbrp_pkg::POS_DATA2, mbrp_pkg::POS_DATA3: begin
            byte_count_in = byte_count_ff + 4'd1;
            crc_in        = crc_next;
         end
         mbrp_pkg::POS_CRC_LOW: begin
            byte_count_in = mbrp_pkg::POS_CRC_HIGH;
         end
         mbrp_pkg::POS_CRC_HIGH: begin
            byte_count_in = mbrp_pkg::POS_ADDR;
            crc_in        = mbrp_pkg::CRC_INIT;
            q_push        = accept;
         end
         default: begin
            byte_count_in = mbrp_pkg::POS_ADDR;
            crc_in        = mbrp_pkg::CRC_INIT;
         end
      endcase
   end

   always_comb begin
      q_entry.crc_ok      = crc_match;
      q_entry.first_word  = crc_match ? {payload_ff[0], payload_ff[1]} : '0;
      q_entry.second_word = crc_match ? {payload_ff[2], payload_ff[3]} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= mbrp_pkg::POS_ADDR;
         crc_ff        <= mbrp_pkg::CRC_INIT;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (byte_count_ff >= mbrp_pkg::POS_DATA0 && byte_count_ff <= mbrp_pkg::POS_DATA3) begin
            payload_ff[data_idx] <= req_tdata;
         end
         if (byte_count_ff == mbrp_pkg::POS_CRC_LOW) begin
            crc_low_ff <= req_tdata;
         end
      end
   end

endmodule

FILE: hdl/mbrp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus read response parser frame queue
// Small FIFO of completed frames between the front end and the back end.
// ----------------------------------------------------------------------------
module mbrp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbrp_pkg::frame_type  push_entry,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 pop_valid,
   output mbrp_pkg::frame_type  pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mbrp_pkg::frame_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hdl/mbrp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus read response parser back end
// Scales both registers by one tenth and holds the result transfer.
// ----------------------------------------------------------------------------
module mbrp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  mbrp_pkg::frame_type               q_entry,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mbrp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int PROD_W = 33;

   logic                             rsp_valid_ff;
   logic [mbrp_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                             rsp_user_ff;
   logic [PROD_W-1:0]                prod_first, prod_second;
   logic [mbrp_pkg::VALUE_W-1:0]     first_value, second_value;

   assign q_pop = q_valid & (~rsp_valid_ff | rsp_tready);

   assign prod_first   = PROD_W'(q_entry.first_word)  * PROD_W'(mbrp_pkg::DIV10_MULT);
   assign prod_second  = PROD_W'(q_entry.second_word) * PROD_W'(mbrp_pkg::DIV10_MULT);
   assign first_value  = prod_first[mbrp_pkg::DIV10_SHIFT +: mbrp_pkg::VALUE_W];
   assign second_value = prod_second[mbrp_pkg::DIV10_SHIFT +: mbrp_pkg::VALUE_W];
   assign rsp_data_in  = {{mbrp_pkg::PAD_W{1'b0}}, second_value, first_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= q_entry.crc_ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
